>>> rtl/fure_pkg.sv
// fure_pkg: shared types, codes and constants of the flash update report engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fure_pkg;

    localparam int          REPORT_WORDS_DEF    = 16;
    localparam logic [31:0] PAGE_ALIGN_MASK_DEF = 32'h0000_007F;

    localparam logic [31:0] CMD_RST     = 32'h0000_0000;
    localparam logic [31:0] CMD_PRG     = 32'h0000_0080;
    localparam logic [31:0] CMD_RD      = 32'h0000_0040;
    localparam logic [31:0] HALF_OFFSET = 32'h0000_0040;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [1:0] OP_LINK_CFG    = 2'd0;
    localparam logic [1:0] OP_WORD        = 2'd1;
    localparam logic [1:0] OP_STATUS_SENT = 2'd2;
    localparam logic [1:0] OP_SHORT       = 2'd3;

    localparam logic [1:0] ACT_STATUS = 2'd0;
    localparam logic [1:0] ACT_ARM    = 2'd1;
    localparam logic [1:0] ACT_ERASE  = 2'd2;
    localparam logic [1:0] ACT_WRITE  = 2'd3;

    localparam logic [2:0] CODE_OK        = 3'd0;
    localparam logic [2:0] CODE_SEQUENCE  = 3'd1;
    localparam logic [2:0] CODE_BAD_CMD   = 3'd2;
    localparam logic [2:0] CODE_BAD_ADDR  = 3'd3;
    localparam logic [2:0] CODE_BAD_CRC   = 3'd4;
    localparam logic [2:0] CODE_WRITE_ERR = 3'd5;
    localparam logic [2:0] CODE_SHORT     = 3'd6;

    localparam logic REG_LOW_BOUND  = 1'b0;
    localparam logic REG_HIGH_BOUND = 1'b1;

    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_STATUS = 3'd1,
        MODE_LPROG  = 3'd2,
        MODE_UPROG  = 3'd3,
        MODE_LREAD  = 3'd4
    } mode_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] report_word;
        logic        last_word;
        logic        write_ok;
    } evt_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] flash_address;
        logic [31:0] status_command;
        logic [2:0]  status_code;
        logic [31:0] status_crc_low;
        logic [31:0] status_crc_high;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } push_t;

    // CRC-32 remainder contributed by a single set bit of (crc ^ word)
    function automatic logic [31:0] crc_unit(input int idx);
        logic [31:0] c;
        c = 32'h0000_0001 << idx;
        for (int b = 0; b < 32; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/flash_update_report_engine_core.sv
// Flash update report engine: firmware-update protocol with 32-bit parallel CRC-32.
// An accepted item is held in the input register, then one pass of control and CRC logic
// writes its results into a four-entry result queue; two results leave the port in order.
// Throughput: one item per cycle while the result queue has room (evt_stall otherwise).
// Reset (rst_n, async, active low): idle mode, CRC all ones, bounds 0 and all ones, queue empty.
// Depends on fure_pkg, fure_ctrl, fure_crc32 and fure_outq.
`timescale 1ns / 1ps

module flash_update_report_engine_core
    import fure_pkg::*;
#(
    parameter int          REPORT_WORDS    = REPORT_WORDS_DEF,
    parameter logic [31:0] PAGE_ALIGN_MASK = PAGE_ALIGN_MASK_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        evt_valid,
    output logic        evt_stall,
    input  evt_t        evt,
    output logic        res_valid,
    input  logic        res_stall,
    output res_t        res,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    push_t push;
    logic  room;

    assign cfg_ready = 1'b1;

    fure_ctrl #(
        .REPORT_WORDS    (REPORT_WORDS),
        .PAGE_ALIGN_MASK (PAGE_ALIGN_MASK)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .room      (room),
        .push      (push)
    );

    fure_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

>>> rtl/fure_crc32.sv
// fure_crc32: one-word parallel CRC-32 (reflected, poly 0xEDB88320) update.
// Depends on fure_pkg for the column constants.
`timescale 1ns / 1ps

module fure_crc32
    import fure_pkg::*;
(
    input  logic [31:0] crc_in,
    input  logic [31:0] word,
    output logic [31:0] crc_out
);

    logic [31:0] col [32];
    logic [31:0] x;

    for (genvar g = 0; g < 32; g++) begin : g_col
        assign col[g] = crc_unit(g);
    end

    assign x = crc_in ^ word;

    always_comb
    begin
        crc_out = '0;
        for (int i = 0; i < 32; i++) begin
            if (x[i])
            begin
                crc_out = crc_out ^ col[i];
            end
        end
    end

endmodule

>>> rtl/fure_outq.sv
// fure_outq: four-entry result queue, takes up to two results per cycle.
// Depends on fure_pkg for res_t and push_t.
`timescale 1ns / 1ps

module fure_outq
    import fure_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    output logic  room,
    output logic  res_valid,
    input  logic  res_stall,
    output res_t  res
);

    res_t                  mem_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next, wr_ptr_p1;
    logic [OUTQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUTQ_CNT_W-1:0] count_reg, count_next;
    logic                  pop;

    assign res_valid = (count_reg != '0);
    assign res       = mem_reg[rd_ptr_reg];
    assign pop       = res_valid && !res_stall;
    assign room      = (count_reg <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));
    assign wr_ptr_p1 = wr_ptr_reg + OUTQ_PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + OUTQ_PTR_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + OUTQ_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + OUTQ_CNT_W'(push.count) - OUTQ_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_p1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/fure_ctrl.sv
// fure_ctrl: input item register, protocol state, CRC tracking and result build.
// Depends on fure_pkg and fure_crc32.
`timescale 1ns / 1ps

module fure_ctrl
    import fure_pkg::*;
#(
    parameter int          REPORT_WORDS    = REPORT_WORDS_DEF,
    parameter logic [31:0] PAGE_ALIGN_MASK = PAGE_ALIGN_MASK_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        evt_valid,
    output logic        evt_stall,
    input  evt_t        evt,
    input  logic        cfg_valid,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        room,
    output push_t       push
);

    localparam int WC_W = $clog2(REPORT_WORDS);
    localparam logic [WC_W-1:0] WC_MAX = WC_W'(REPORT_WORDS - 1);

    logic        in_valid_reg, in_valid_next;
    evt_t        in_reg;
    logic        go;

    logic [31:0] low_bound_reg, high_bound_reg;

    mode_t       mode_reg, mode_next;
    mode_t       ret_reg, ret_next;
    logic [WC_W-1:0] wc_reg, wc_next;
    logic [31:0] cmd_reg, cmd_next;
    logic [31:0] page_reg, page_next;
    logic [31:0] exp_lo_reg, exp_lo_next;
    logic [31:0] exp_hi_reg, exp_hi_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] rcmd_reg, rcmd_next;
    logic [2:0]  rcode_reg, rcode_next;
    logic [31:0] rlo_reg, rlo_next;
    logic [31:0] rhi_reg, rhi_next;

    logic [31:0] crc_word;
    logic [31:0] computed;
    logic        upper;
    logic        bad_addr;
    logic [1:0]  n;
    logic [1:0]  act0;
    logic [31:0] addr0;
    logic        status_first;

    fure_crc32 u_crc (
        .crc_in  (crc_reg),
        .word    (in_reg.report_word),
        .crc_out (crc_word)
    );

    assign go            = in_valid_reg && room;
    assign evt_stall     = in_valid_reg && !room;
    assign in_valid_next = (evt_valid && !evt_stall) ? 1'b1 : (go ? 1'b0 : in_valid_reg);
    assign computed      = ~crc_word;
    assign upper         = (mode_reg == MODE_UPROG);

    always_comb
    begin
        mode_next    = mode_reg;
        ret_next     = ret_reg;
        wc_next      = wc_reg;
        cmd_next     = cmd_reg;
        page_next    = page_reg;
        exp_lo_next  = exp_lo_reg;
        exp_hi_next  = exp_hi_reg;
        crc_next     = crc_reg;
        rcmd_next    = rcmd_reg;
        rcode_next   = rcode_reg;
        rlo_next     = rlo_reg;
        rhi_next     = rhi_reg;
        n            = 2'd0;
        act0         = ACT_STATUS;
        addr0        = '0;
        status_first = 1'b1;
        bad_addr     = 1'b0;

        unique case (in_reg.opcode)
            OP_LINK_CFG:
            begin
                wc_next   = '0;
                crc_next  = CRC_INIT;
                mode_next = MODE_IDLE;
                n         = 2'd1;
                act0      = ACT_ARM;
            end
            OP_STATUS_SENT:
            begin
                wc_next  = '0;
                crc_next = CRC_INIT;
                n        = 2'd1;
                if (mode_reg == MODE_STATUS)
                begin
                    mode_next = ret_reg;
                    act0      = ACT_ARM;
                end
                else
                begin
                    rcmd_next  = '0;
                    rcode_next = CODE_SEQUENCE;
                    rlo_next   = '0;
                    rhi_next   = '0;
                    ret_next   = MODE_IDLE;
                    mode_next  = MODE_STATUS;
                end
            end
            OP_SHORT:
            begin
                wc_next    = '0;
                crc_next   = CRC_INIT;
                n          = 2'd1;
                rcmd_next  = '0;
                rcode_next = CODE_SHORT;
                rlo_next   = '0;
                rhi_next   = '0;
                ret_next   = MODE_IDLE;
                mode_next  = MODE_STATUS;
            end
            OP_WORD:
            begin
                if (mode_reg == MODE_IDLE)
                begin
                    if (wc_reg == WC_W'(0)) cmd_next = in_reg.report_word;
                    if (wc_reg == WC_W'(1)) page_next = in_reg.report_word;
                    if (wc_reg == WC_W'(2)) exp_lo_next = in_reg.report_word;
                    if (wc_reg == WC_W'(3)) exp_hi_next = in_reg.report_word;
                end
                crc_next = crc_word;
                if (!in_reg.last_word)
                begin
                    if (wc_reg < WC_MAX)
                    begin
                        wc_next = wc_reg + WC_W'(1);
                    end
                end
                else
                begin
                    wc_next   = '0;
                    crc_next  = CRC_INIT;
                    mode_next = MODE_STATUS;
                    ret_next  = MODE_IDLE;
                    n         = 2'd1;
                    priority if (mode_reg == MODE_IDLE)
                    begin
                        rlo_next = '0;
                        rhi_next = '0;
                        priority if (cmd_next == CMD_RST)
                        begin
                            rcmd_next  = CMD_RST;
                            rcode_next = CODE_OK;
                        end
                        else if (cmd_next == CMD_PRG)
                        begin
                            rcmd_next = CMD_PRG;
                            bad_addr  = ((page_next & PAGE_ALIGN_MASK) != '0) ||
                                        (page_next < low_bound_reg) ||
                                        (page_next > high_bound_reg);
                            if (bad_addr)
                            begin
                                rcode_next = CODE_BAD_ADDR;
                            end
                            else
                            begin
                                rcode_next   = CODE_OK;
                                ret_next     = MODE_LPROG;
                                n            = 2'd2;
                                act0         = ACT_ERASE;
                                addr0        = page_next;
                                status_first = 1'b0;
                            end
                        end
                        else if (cmd_next == CMD_RD)
                        begin
                            rcmd_next  = CMD_RD;
                            rcode_next = CODE_OK;
                            ret_next   = MODE_LREAD;
                        end
                        else
                        begin
                            rcmd_next  = cmd_next;
                            rcode_next = CODE_BAD_CMD;
                        end
                    end
                    else if (mode_reg == MODE_LPROG || mode_reg == MODE_UPROG)
                    begin
                        if (upper) rhi_next = computed;
                        else       rlo_next = computed;
                        if (computed != (upper ? exp_hi_reg : exp_lo_reg))
                        begin
                            rcode_next = CODE_BAD_CRC;
                        end
                        else
                        begin
                            n            = 2'd2;
                            act0         = ACT_WRITE;
                            addr0        = upper ? page_reg + HALF_OFFSET : page_reg;
                            status_first = 1'b0;
                            if (!in_reg.write_ok)
                            begin
                                rcode_next = CODE_WRITE_ERR;
                            end
                            else
                            begin
                                rcode_next = CODE_OK;
                                ret_next   = upper ? MODE_IDLE : MODE_UPROG;
                            end
                        end
                    end
                    else
                    begin
                        rcmd_next  = '0;
                        rcode_next = CODE_SEQUENCE;
                        rlo_next   = '0;
                        rhi_next   = '0;
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        push = '0;
        if (go)
        begin
            push.count = n;
        end
        push.first.action        = act0;
        push.first.flash_address = addr0;
        push.first.last          = (n == 2'd1);
        if (status_first && act0 == ACT_STATUS)
        begin
            push.first.status_command  = rcmd_next;
            push.first.status_code     = rcode_next;
            push.first.status_crc_low  = rlo_next;
            push.first.status_crc_high = rhi_next;
        end
        push.second.action          = ACT_STATUS;
        push.second.status_command  = rcmd_next;
        push.second.status_code     = rcode_next;
        push.second.status_crc_low  = rlo_next;
        push.second.status_crc_high = rhi_next;
        push.second.last            = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (evt_valid && !evt_stall)
        begin
            in_reg <= evt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            low_bound_reg  <= '0;
            high_bound_reg <= '1;
            mode_reg       <= MODE_IDLE;
            ret_reg        <= MODE_IDLE;
            wc_reg         <= '0;
            cmd_reg        <= '0;
            page_reg       <= '0;
            exp_lo_reg     <= '0;
            exp_hi_reg     <= '0;
            crc_reg        <= CRC_INIT;
            rcmd_reg       <= '0;
            rcode_reg      <= CODE_OK;
            rlo_reg        <= '0;
            rhi_reg        <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (cfg_valid)
            begin
                if (cfg_index == REG_LOW_BOUND)  low_bound_reg  <= cfg_data;
                if (cfg_index == REG_HIGH_BOUND) high_bound_reg <= cfg_data;
            end
            if (go)
            begin
                mode_reg   <= mode_next;
                ret_reg    <= ret_next;
                wc_reg     <= wc_next;
                cmd_reg    <= cmd_next;
                page_reg   <= page_next;
                exp_lo_reg <= exp_lo_next;
                exp_hi_reg <= exp_hi_next;
                crc_reg    <= crc_next;
                rcmd_reg   <= rcmd_next;
                rcode_reg  <= rcode_next;
                rlo_reg    <= rlo_next;
                rhi_reg    <= rhi_next;
            end
        end
    end

endmodule

>>> tb/tb_flash_update_report_engine_core.sv
// Self-checking testbench for flash_update_report_engine_core: host events in, action items out,
// bound registers written between phases, every answer checked against an internal protocol model.
// Depends on fure_pkg and the RTL of the engine; nothing else.
`timescale 1ns / 1ps

module tb_flash_update_report_engine_core;
    import fure_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HALF_PHASE_EVENTS = 113;
    localparam int NUM_PHASES = 6;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic evt_valid = 1'b0;
    logic evt_stall;
    evt_t evt = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = REG_LOW_BOUND;
    logic [31:0] cfg_data = '0;

    flash_update_report_engine_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // protocol model state
    mode_t       md = MODE_IDLE;
    mode_t       md_ret = MODE_IDLE;
    logic [3:0]  wcnt = '0;
    logic [31:0] cmd_q = '0;
    logic [31:0] page_q = '0;
    logic [31:0] crc_lo_want = '0;
    logic [31:0] crc_hi_want = '0;
    logic [31:0] crc_run = CRC_INIT;
    logic [31:0] st_cmd = '0;
    logic [2:0]  st_code = CODE_OK;
    logic [31:0] st_crc_lo = '0;
    logic [31:0] st_crc_hi = '0;
    logic [31:0] bound_lo = '0;
    logic [31:0] bound_hi = 32'hFFFF_FFFF;

    res_t        answers[$];
    evt_t        host_events[$];
    logic [31:0] words[$];

    int unsigned cycles = 0;
    int unsigned errs = 0;
    int unsigned evt_queued = 0;
    int unsigned evt_done = 0;
    int unsigned n_checked = 0;
    int unsigned n_writes = 0;
    int unsigned n_settings = 0;

    bit   evt_took = 1'b0;
    bit   evt_busy = 1'b0;
    bit   evt_calm = 1'b0;
    int   evt_gap = 0;
    evt_t evt_cur = '0;
    bit   res_took = 1'b0;
    bit   res_calm = 1'b0;
    int   res_wait = 0;

    function automatic logic [31:0] crc32_word(input logic [31:0] c, input logic [31:0] w);
        logic [31:0] r;
        r = c ^ w;
        for (int b = 0; b < 32; b++)
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    task automatic push_answer(input logic [1:0] act, input logic [31:0] addr, input logic fin);
        res_t r;
        r = '0;
        r.action = act;
        r.flash_address = addr;
        r.last = fin;
        if (act == ACT_STATUS)
        begin
            r.status_command = st_cmd;
            r.status_code = st_code;
            r.status_crc_low = st_crc_lo;
            r.status_crc_high = st_crc_hi;
        end
        if (act == ACT_WRITE)
            n_writes++;
        answers.push_back(r);
    endtask

    task automatic set_status(input logic [31:0] cmd, input logic [2:0] code);
        st_cmd = cmd;
        st_code = code;
        st_crc_lo = '0;
        st_crc_hi = '0;
    endtask

    task automatic go_status(input mode_t ret);
        md_ret = ret;
        md = MODE_STATUS;
        push_answer(ACT_STATUS, '0, 1'b1);
    endtask

    task automatic finish_command();
        if (cmd_q == CMD_RST)
        begin
            set_status(CMD_RST, CODE_OK);
            go_status(MODE_IDLE);
        end
        else if (cmd_q == CMD_PRG)
        begin
            set_status(CMD_PRG, CODE_OK);
            if ((page_q & PAGE_ALIGN_MASK_DEF) != '0 || page_q < bound_lo || page_q > bound_hi)
            begin
                st_code = CODE_BAD_ADDR;
                go_status(MODE_IDLE);
            end
            else
            begin
                push_answer(ACT_ERASE, page_q, 1'b0);
                go_status(MODE_LPROG);
            end
        end
        else if (cmd_q == CMD_RD)
        begin
            set_status(CMD_RD, CODE_OK);
            go_status(MODE_LREAD);
        end
        else
        begin
            set_status(cmd_q, CODE_BAD_CMD);
            go_status(MODE_IDLE);
        end
    endtask

    task automatic finish_half(input logic wok);
        logic        upper;
        logic [31:0] got;
        upper = (md == MODE_UPROG);
        got = ~crc_run;
        if (upper)
            st_crc_hi = got;
        else
            st_crc_lo = got;
        if (got != (upper ? crc_hi_want : crc_lo_want))
        begin
            st_code = CODE_BAD_CRC;
            go_status(MODE_IDLE);
        end
        else
        begin
            push_answer(ACT_WRITE, upper ? page_q + HALF_OFFSET : page_q, 1'b0);
            if (!wok)
            begin
                st_code = CODE_WRITE_ERR;
                go_status(MODE_IDLE);
            end
            else
            begin
                st_code = CODE_OK;
                go_status(upper ? MODE_IDLE : MODE_UPROG);
            end
        end
    endtask

    task automatic answer_event(input evt_t e);
        if (e.opcode != OP_WORD)
        begin
            wcnt = '0;
            crc_run = CRC_INIT;
        end
        case (e.opcode)
            OP_LINK_CFG:
            begin
                md = MODE_IDLE;
                push_answer(ACT_ARM, '0, 1'b1);
            end
            OP_STATUS_SENT:
            begin
                if (md == MODE_STATUS)
                begin
                    md = md_ret;
                    push_answer(ACT_ARM, '0, 1'b1);
                end
                else
                begin
                    set_status('0, CODE_SEQUENCE);
                    go_status(MODE_IDLE);
                end
            end
            OP_SHORT:
            begin
                set_status('0, CODE_SHORT);
                go_status(MODE_IDLE);
            end
            default:
            begin
                if (md == MODE_IDLE)
                begin
                    case (wcnt)
                        4'd0: cmd_q = e.report_word;
                        4'd1: page_q = e.report_word;
                        4'd2: crc_lo_want = e.report_word;
                        4'd3: crc_hi_want = e.report_word;
                        default: ;
                    endcase
                end
                crc_run = crc32_word(crc_run, e.report_word);
                if (!e.last_word)
                begin
                    if (wcnt < 4'(REPORT_WORDS_DEF - 1))
                        wcnt++;
                end
                else
                begin
                    if (md == MODE_IDLE)
                        finish_command();
                    else if (md == MODE_LPROG || md == MODE_UPROG)
                        finish_half(e.write_ok);
                    else
                    begin
                        set_status('0, CODE_SEQUENCE);
                        go_status(MODE_IDLE);
                    end
                    wcnt = '0;
                    crc_run = CRC_INIT;
                end
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            errs++;
        end
    endtask

    task automatic check_answer(input res_t got);
        res_t want;
        if (answers.size() == 0)
        begin
            $error("unexpected item: action %0d address 0x%08h", got.action, got.flash_address);
            errs++;
        end
        else
        begin
            want = answers.pop_front();
            n_checked++;
            compare_field("action", 32'(want.action), 32'(got.action));
            compare_field("flash_address", want.flash_address, got.flash_address);
            compare_field("status_command", want.status_command, got.status_command);
            compare_field("status_code", 32'(want.status_code), 32'(got.status_code));
            compare_field("status_crc_low", want.status_crc_low, got.status_crc_low);
            compare_field("status_crc_high", want.status_crc_high, got.status_crc_high);
            compare_field("last", 32'(want.last), 32'(got.last));
        end
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (rst_n)
        begin
            if (evt_valid && !evt_stall)
            begin
                answer_event(evt);
                evt_done++;
                evt_took = 1'b1;
            end
            if (res_valid && !res_stall)
            begin
                check_answer(res);
                res_took = 1'b1;
            end
        end
    end

    // event driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (evt_took)
            begin
                evt_took = 1'b0;
                evt_busy = 1'b0;
            end
            if (!evt_busy && host_events.size() > 0)
            begin
                if (evt_gap > 0)
                    evt_gap--;
                else
                begin
                    evt_cur = host_events.pop_front();
                    evt_busy = 1'b1;
                    if ($urandom_range(0, 49) == 0)
                        evt_calm = !evt_calm;
                    evt_gap = evt_calm ? 0 : $urandom_range(0, 9);
                end
            end
            evt_valid <= evt_busy;
            evt <= evt_cur;
        end
    end

    // result stall
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (res_took)
            begin
                res_took = 1'b0;
                if ($urandom_range(0, 39) == 0)
                    res_calm = !res_calm;
                res_wait = res_calm ? 0 : $urandom_range(0, 9);
            end
            res_stall <= (res_wait > 0);
            if (res_wait > 0)
                res_wait--;
        end
    end

    task automatic push_evt(input logic [1:0] op, input logic [31:0] w, input logic lw,
                            input logic wok);
        evt_t e;
        e.opcode = op;
        e.report_word = w;
        e.last_word = lw;
        e.write_ok = wok;
        host_events.push_back(e);
        evt_queued++;
    endtask

    task automatic push_ctl(input logic [1:0] op);
        push_evt(op, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    function automatic logic [1:0] pick_ctl();
        case ($urandom_range(0, 2))
            0: return OP_LINK_CFG;
            1: return OP_STATUS_SENT;
            default: return OP_SHORT;
        endcase
    endfunction

    task automatic push_report(input logic wok);
        for (int i = 0; i < words.size(); i++)
        begin
            if (i == words.size() - 1)
                push_evt(OP_WORD, words[i], 1'b1, wok);
            else
                push_evt(OP_WORD, words[i], 1'b0, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic one_word_report(input logic [31:0] w, input logic wok);
        words.delete();
        words.push_back(w);
        push_report(wok);
    endtask

    function automatic int report_len();
        case ($urandom_range(0, 9))
            8: return $urandom_range(1, REPORT_WORDS_DEF - 1);
            9: return $urandom_range(REPORT_WORDS_DEF + 1, REPORT_WORDS_DEF + 4);
            default: return REPORT_WORDS_DEF;
        endcase
    endfunction

    function automatic logic [31:0] data_word();
        case ($urandom_range(0, 15))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic fill_words(input int len);
        words.delete();
        repeat (len) words.push_back(data_word());
    endtask

    function automatic logic [31:0] words_crc();
        logic [31:0] c;
        c = CRC_INIT;
        foreach (words[i])
            c = crc32_word(c, words[i]);
        return ~c;
    endfunction

    task automatic build_command(input logic [31:0] cmd, input logic [31:0] page,
                                 input logic [31:0] crcl, input logic [31:0] crch,
                                 input int len);
        words.delete();
        words.push_back(cmd);
        words.push_back(page);
        words.push_back(crcl);
        words.push_back(crch);
        while (words.size() < len)
            words.push_back(data_word());
        while (words.size() > len)
            void'(words.pop_back());
    endtask

    function automatic logic [31:0] pick_page();
        logic [32:0] base;
        logic [31:0] span;
        base = {1'b0, bound_lo} + {1'b0, PAGE_ALIGN_MASK_DEF};
        base[31:0] = base[31:0] & ~PAGE_ALIGN_MASK_DEF;
        if ($urandom_range(0, 5) == 0 || base > {1'b0, bound_hi})
            return $urandom;
        span = (bound_hi - base[31:0]) >> 7;
        case ($urandom_range(0, 5))
            0: return base[31:0];
            1: return base[31:0] + (span << 7);
            2: return base[31:0] - 32'h80;
            3: return base[31:0] + (span << 7) + 32'h80;
            default: return base[31:0] + ($urandom_range(0, span) << 7);
        endcase
    endfunction

    task automatic program_sequence();
        logic [31:0] lo_words[$];
        logic [31:0] hi_words[$];
        logic [31:0] crc_lo;
        logic [31:0] crc_hi;
        int          flaw;
        fill_words(report_len());
        crc_lo = words_crc();
        lo_words = words;
        fill_words(report_len());
        crc_hi = words_crc();
        hi_words = words;
        flaw = $urandom_range(0, 13);
        if (flaw == 6)
            crc_lo ^= 32'h1 << $urandom_range(0, 31);
        if (flaw == 7)
            crc_hi ^= 32'h1 << $urandom_range(0, 31);
        build_command(CMD_PRG, pick_page(), crc_lo, crc_hi,
                      ($urandom_range(0, 9) == 0) ? report_len() : REPORT_WORDS_DEF);
        push_report(1'($urandom_range(0, 1)));
        if (flaw != 8)
            push_ctl(OP_STATUS_SENT);
        if (flaw == 11)
            push_ctl(OP_LINK_CFG);
        words = lo_words;
        push_report(flaw != 9);
        push_ctl(OP_STATUS_SENT);
        if (flaw == 10)
            push_ctl(OP_SHORT);
        words = hi_words;
        push_report(flaw != 12);
        push_ctl(OP_STATUS_SENT);
    endtask

    task automatic misc_sequence();
        case ($urandom_range(0, 9))
            0:
            begin
                build_command(CMD_RST, $urandom, $urandom, $urandom, report_len());
                push_report(1'($urandom_range(0, 1)));
                push_ctl(OP_STATUS_SENT);
            end
            1:
            begin
                build_command(CMD_RD, $urandom, $urandom, $urandom, report_len());
                push_report(1'($urandom_range(0, 1)));
                push_ctl(OP_STATUS_SENT);
                fill_words(report_len());
                push_report(1'($urandom_range(0, 1)));
                push_ctl(OP_STATUS_SENT);
            end
            2:
            begin
                build_command(data_word(), $urandom, $urandom, $urandom, report_len());
                push_report(1'($urandom_range(0, 1)));
                push_ctl(OP_STATUS_SENT);
            end
            3: push_ctl(OP_LINK_CFG);
            4:
            begin
                push_ctl(OP_SHORT);
                push_ctl(OP_STATUS_SENT);
            end
            5: push_ctl(OP_STATUS_SENT);
            6:
            begin
                repeat ($urandom_range(1, 5))
                    push_evt(OP_WORD, data_word(), 1'b0, 1'($urandom_range(0, 1)));
                push_ctl(pick_ctl());
            end
            7:
            begin
                repeat ($urandom_range(1, 6))
                    push_evt(2'($urandom_range(0, 3)), data_word(), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
            end
            8:
            begin
                build_command(CMD_PRG, data_word(), $urandom, $urandom, report_len());
                push_report(1'($urandom_range(0, 1)));
                push_ctl(OP_STATUS_SENT);
            end
            default:
            begin
                push_ctl(OP_STATUS_SENT);
                push_ctl(OP_LINK_CFG);
            end
        endcase
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned target;
        target = evt_queued + count;
        while (evt_queued < target)
        begin
            if ($urandom_range(0, 9) < 6)
                program_sequence();
            else
                misc_sequence();
        end
    endtask

    task automatic drain();
        while (evt_done != evt_queued || answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_bound(input logic idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_LOW_BOUND)
            bound_lo = val;
        else
            bound_hi = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_bounds(input logic [31:0] lo, input logic [31:0] hi);
        write_bound(REG_LOW_BOUND, lo);
        write_bound(REG_HIGH_BOUND, hi);
        n_settings++;
    endtask

    task automatic directed_events();
        logic [31:0] crc_lo;
        logic [31:0] crc_hi;
        push_ctl(OP_LINK_CFG);
        push_ctl(OP_STATUS_SENT);   // status-sent while idle
        push_ctl(OP_STATUS_SENT);
        one_word_report(32'hFFFF_FFFF, 1'b1);
        push_ctl(OP_SHORT);
        push_ctl(OP_STATUS_SENT);
        one_word_report(CMD_RD, 1'b1);
        push_ctl(OP_STATUS_SENT);
        one_word_report(32'h0000_0000, 1'b0);   // report after read
        push_ctl(OP_STATUS_SENT);
        build_command(CMD_PRG, PAGE_ALIGN_MASK_DEF, '0, '0, 2);   // misaligned page
        push_report(1'b1);
        push_ctl(OP_STATUS_SENT);
        one_word_report(32'h0000_0000, 1'b0);
        words.delete();
        words.push_back(32'h0000_0000);
        crc_lo = words_crc();
        words.delete();
        words.push_back(32'hFFFF_FFFF);
        crc_hi = words_crc();
        // the stray report word queued above is dropped; only the CRCs are needed
        void'(host_events.pop_back());
        evt_queued -= 1;
        build_command(CMD_PRG, 32'hFFFF_FF80, crc_lo, crc_hi, 4);
        push_report(1'b1);
        push_ctl(OP_STATUS_SENT);
        one_word_report(32'h0000_0000, 1'b1);
        push_ctl(OP_STATUS_SENT);
        one_word_report(32'hFFFF_FFFF, 1'b0);   // upper half write fails
        push_ctl(OP_STATUS_SENT);
    endtask

    initial
    begin
        while (cycles < CYCLE_LIMIT)
            @(posedge clk);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        logic [31:0] lo;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        directed_events();
        drain();
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: set_bounds(32'h0000_0000, 32'hFFFF_FFFF);
                1: set_bounds(32'h0000_0000, 32'h0000_0000);
                2: set_bounds(32'hFFFF_FF80, 32'hFFFF_FFFF);
                3: set_bounds(32'h0002_0000, 32'h0003_FFFF);
                4: set_bounds(32'hFFFF_FFFF, 32'h0000_0000);
                default:
                begin
                    lo = $urandom_range(0, 32'h7FFF_FFFF);
                    set_bounds(lo, lo + $urandom_range(0, 32'h0010_0000));
                end
            endcase
            run_random(HALF_PHASE_EVENTS);
            drain();
            run_random(HALF_PHASE_EVENTS);
            drain();
        end
        $display("Covered %0d host events under %0d bound settings plus reset values;",
                 evt_done, n_settings);
        $display("checked %0d answer items, %0d of them half-page writes.",
                 n_checked, n_writes);
        if (errs == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
